// File: sv/wbl_pkg.sv
`timescale 1ns / 1ps
// Package: types, codes and constants of the two-queue weighted batch loader.
package wbl_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int BATCH_W   = 5;
	localparam int RATIO_W   = 4;
	localparam int CFG_ADDR_W = 3;

	localparam logic [BATCH_W-1:0] MAX_BATCH   = 5'd16;
	localparam logic [BATCH_W-1:0] BATCH_RESET = 5'd10;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd4;

	localparam logic REG_BATCH = 1'b0;
	localparam logic REG_RATIO = 1'b1;

	typedef enum logic [1:0] {
		CMD_ENQ_HI = 2'd0,
		CMD_ENQ_LO = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_HI   = 2'd0,
		CLS_LO   = 2'd1,
		CLS_NONE = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TAKE,
		S_DATA
	} seq_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] item_value;
	} req_t;

	typedef struct packed {
		cls_t        item_class;
		logic [15:0] out_value;
		status_t     status;
		logic        last;
	} rsp_t;

	// queue occupancy as seen by the sequencer
	typedef struct packed {
		logic empty;
		logic full;
		logic last_one;
	} q_stat_t;

endpackage

// File: sv/wbl_queue.sv
`timescale 1ns / 1ps
// Circular queue: value memory with registered read, head/tail pointers, put flag.
module wbl_queue
	import wbl_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   pop,
	input  logic [VALUE_WIDTH-1:0] wdata,
	output logic [VALUE_WIDTH-1:0] rdata,
	output q_stat_t                stat
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	logic [VALUE_WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic [AW-1:0]          head_q;
	logic [AW-1:0]          tail_q;
	logic                   put_q;
	logic [AW-1:0]          head_nxt;
	logic [AW-1:0]          tail_nxt;

	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);

	assign stat.empty    = (head_q == tail_q) && !put_q;
	assign stat.full     = (head_q == tail_q) && put_q;
	assign stat.last_one = !stat.empty && (head_nxt == tail_q);
	assign rdata         = rdata_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			put_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= tail_nxt;
				put_q  <= 1'b1;
			end
			if (pop) begin
				head_q <= head_nxt;
				put_q  <= 1'b0;
			end
		end
	end

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n) !(push && pop))
		else $error("queue pushed and popped in one cycle");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !stat.full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

// File: sv/wbl_seq.sv
`timescale 1ns / 1ps
// Command sequencer: enqueue, batch selection with weighting, result register.
module wbl_seq
	import wbl_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rsp_t                   rsp,
	input  logic [BATCH_W-1:0]     batch_size,
	input  logic [RATIO_W-1:0]     ratio,
	input  q_stat_t                hi_stat,
	input  q_stat_t                lo_stat,
	input  logic [VALUE_WIDTH-1:0] hi_rdata,
	input  logic [VALUE_WIDTH-1:0] lo_rdata,
	output logic                   hi_push,
	output logic                   hi_pop,
	output logic                   lo_push,
	output logic                   lo_pop,
	output logic [VALUE_WIDTH-1:0] wdata
);

	seq_state_t         state_q;
	seq_state_t         state_nxt;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [RATIO_W-1:0] count_q;
	logic [BATCH_W-1:0] n_q;
	logic [BATCH_W-1:0] limit_q;
	cls_t               sel_q;
	logic               last_q;

	logic               out_free;
	logic               acc;
	logic               both_empty;
	logic [BATCH_W-1:0] limit;
	logic               take_hi;
	logic [RATIO_W-1:0] count_nxt;
	logic               hi_empty_after;
	logic               lo_empty_after;
	logic               last_nxt;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !((state_q == S_IDLE) && out_free);
	assign acc        = req_valid && !req_stall;
	assign both_empty = hi_stat.empty && lo_stat.empty;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign wdata      = VALUE_WIDTH'(req.item_value);

	always_comb begin
		if (batch_size == '0) begin
			limit = BATCH_W'(1);
		end else if (batch_size > MAX_BATCH) begin
			limit = MAX_BATCH;
		end else begin
			limit = batch_size;
		end
	end

	// weighted pick from the current pointers
	always_comb begin
		take_hi   = 1'b1;
		count_nxt = count_q;
		if (!hi_stat.empty && (count_q < ratio)) begin
			count_nxt = count_q + RATIO_W'(1);
		end else if ((count_q >= ratio) && !lo_stat.empty) begin
			take_hi   = 1'b0;
			count_nxt = '0;
		end else if (!lo_stat.empty) begin
			take_hi   = 1'b0;
			count_nxt = count_q + RATIO_W'(1);
		end
		hi_empty_after = take_hi ? hi_stat.last_one : hi_stat.empty;
		lo_empty_after = take_hi ? lo_stat.empty : lo_stat.last_one;
		last_nxt = ((n_q + BATCH_W'(1)) == limit_q) || (hi_empty_after && lo_empty_after);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && (req.cmd == CMD_LOAD) && !both_empty) begin
					state_nxt = S_TAKE;
				end
			end
			S_TAKE: begin
				state_nxt = S_DATA;
			end
			S_DATA: begin
				if (out_free) begin
					state_nxt = last_q ? S_IDLE : S_TAKE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		hi_push = 1'b0;
		lo_push = 1'b0;
		hi_pop  = 1'b0;
		lo_pop  = 1'b0;
		case (state_q)
			S_IDLE: begin
				hi_push = acc && (req.cmd == CMD_ENQ_HI) && !hi_stat.full;
				lo_push = acc && (req.cmd == CMD_ENQ_LO) && !lo_stat.full;
			end
			S_TAKE: begin
				hi_pop = take_hi;
				lo_pop = !take_hi;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			n_q         <= '0;
			limit_q     <= BATCH_W'(1);
			last_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						count_q <= '0;
						n_q     <= '0;
						limit_q <= limit;
						case (req.cmd)
							CMD_ENQ_HI, CMD_ENQ_LO: begin
								rsp_valid_q <= 1'b1;
							end
							CMD_LOAD: begin
								rsp_valid_q <= both_empty;
							end
							default: begin
							end
						endcase
					end
				end
				S_TAKE: begin
					count_q <= count_nxt;
					n_q     <= n_q + BATCH_W'(1);
					last_q  <= last_nxt;
				end
				S_DATA: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && acc) begin
			rsp_q.item_class <= CLS_NONE;
			rsp_q.out_value  <= '0;
			rsp_q.last       <= 1'b1;
			case (req.cmd)
				CMD_ENQ_HI: rsp_q.status <= hi_stat.full ? ST_FULL : ST_OK;
				CMD_ENQ_LO: rsp_q.status <= lo_stat.full ? ST_FULL : ST_OK;
				default:    rsp_q.status <= ST_EMPTY;
			endcase
		end else if ((state_q == S_DATA) && out_free) begin
			rsp_q.item_class <= sel_q;
			rsp_q.out_value  <= (sel_q == CLS_HI) ? 16'(hi_rdata) : 16'(lo_rdata);
			rsp_q.status     <= ST_OK;
			rsp_q.last       <= last_q;
		end
		if (state_q == S_TAKE) begin
			sel_q <= take_hi ? CLS_HI : CLS_LO;
		end
	end

endmodule

// File: sv/two_queue_weighted_batch_loader.sv
`timescale 1ns / 1ps
// Top level: configuration registers, two class queues and the command sequencer.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_t  (cmd, item_value)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_t  (item_class, out_value, status, last)
//  cfg     | in  | psel/penable/pready  | batch_size @0x0, ratio @0x4
//
//  Enqueue and empty load: a result beat in the cycle after acceptance; the next command
//  is taken once the result register is free. Load: per item a pointer update and
//  memory read, then the result register.
//  Reset clears pointers and put flags; queue memories need no clearing pass.
//  A stalled result holds the sequencer; commands are stalled during a batch.
module two_queue_weighted_batch_loader
	import wbl_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [BATCH_W-1:0]     batch_size_q;
	logic [RATIO_W-1:0]     ratio_q;
	q_stat_t                hi_stat;
	q_stat_t                lo_stat;
	logic [VALUE_WIDTH-1:0] hi_rdata;
	logic [VALUE_WIDTH-1:0] lo_rdata;
	logic [VALUE_WIDTH-1:0] wdata;
	logic                   hi_push;
	logic                   hi_pop;
	logic                   lo_push;
	logic                   lo_pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_size_q <= BATCH_RESET;
			ratio_q      <= RATIO_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_BATCH: batch_size_q <= pwdata[BATCH_W-1:0];
				REG_RATIO: ratio_q      <= pwdata[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BATCH: prdata = 32'(batch_size_q);
			REG_RATIO: prdata = 32'(ratio_q);
			default:   prdata = '0;
		endcase
	end

	wbl_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_hi_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (hi_push),
		.pop   (hi_pop),
		.wdata (wdata),
		.rdata (hi_rdata),
		.stat  (hi_stat)
	);

	wbl_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_lo_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (lo_push),
		.pop   (lo_pop),
		.wdata (wdata),
		.rdata (lo_rdata),
		.stat  (lo_stat)
	);

	wbl_seq #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.batch_size(batch_size_q),
		.ratio     (ratio_q),
		.hi_stat   (hi_stat),
		.lo_stat   (lo_stat),
		.hi_rdata  (hi_rdata),
		.lo_rdata  (lo_rdata),
		.hi_push   (hi_push),
		.hi_pop    (hi_pop),
		.lo_push   (lo_push),
		.lo_pop    (lo_pop),
		.wdata     (wdata)
	);

endmodule
